// ----- hdl/pba_pkg.sv -----
// Package for the power-of-two bucket allocator: sizes, header and list-head
// encodings, status codes and the size-class mapping.
// No dependencies; the controller, top level and testbench refer to it by scoped names.
package pba_pkg;

    // Heap geometry
    localparam int HEAP_BYTES  = 65536;
    localparam int PAGE_BYTES  = 4096;
    localparam int NUM_CLASSES = 13;

    localparam int ADDR_W      = $clog2(HEAP_BYTES);
    localparam int GRAN_W      = ADDR_W - 3;
    localparam int GRANULES    = HEAP_BYTES / 8;
    localparam int PAGE_SH     = $clog2(PAGE_BYTES);
    localparam int PAGE_GRAN   = PAGE_BYTES / 8;
    localparam int PG_W        = PAGE_SH - 3;
    localparam int CLS_W       = 4;
    localparam int NUM_HEADS   = NUM_CLASSES + 1;
    localparam int POOL        = NUM_CLASSES;
    localparam int PAGE_CLASS  = PAGE_SH - 3;
    localparam int MIN_RECLAIM_CLASS = 2;
    localparam int REQ_W       = 24;
    localparam int LIM_W       = REQ_W + 2;

    // Header word: [17] allocated, [16] link valid, [15:0] link byte offset
    // or, when allocated, the class in the low bits.
    localparam int HDR_W       = ADDR_W + 2;
    localparam int HDR_ALLOC_B = ADDR_W + 1;
    localparam int HDR_LINK_B  = ADDR_W;
    localparam int HDR_CLS_W   = 5;

    // List head: [16] empty, [15:0] byte offset of the first block.
    localparam int HEAD_W      = ADDR_W + 1;
    localparam int HEAD_NULL_B = ADDR_W;

    typedef logic [HDR_W-1:0]  hdr_t;
    typedef logic [HEAD_W-1:0] head_t;

    localparam head_t HEAD_EMPTY = {1'b1, {ADDR_W{1'b0}}};

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2,
        ST_CORRUPT = 2'd3
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Header memory access from the sequencer
    typedef struct packed {
        logic              rd_en;
        logic [GRAN_W-1:0] rd_addr;
        logic              wr_en;
        logic [GRAN_W-1:0] wr_addr;
        hdr_t              wr_data;
    } mem_req_t;

    // Successor head encoded in a header; allocated or unlinked means empty.
    function automatic head_t head_of_link(input hdr_t hdr);
        head_t r;
        if (hdr[HDR_ALLOC_B] || !hdr[HDR_LINK_B])
            r = HEAD_EMPTY;
        else
            r = {1'b0, hdr[ADDR_W-1:0]};
        return r;
    endfunction

    // Header that links on to the given head.
    function automatic hdr_t link_of_head(input head_t head);
        hdr_t r;
        if (head[HEAD_NULL_B])
            r = '0;
        else
            r = {1'b0, 1'b1, head[ADDR_W-1:0]};
        return r;
    endfunction

    // Size class of a request: returns {ok, k}.
    function automatic logic [CLS_W:0] class_of(input logic [REQ_W-1:0] req);
        logic [LIM_W-1:0] lim;
        logic             small_req;
        logic             found;
        logic [CLS_W-1:0] k;
        small_req = ({2'b00, req} <= LIM_W'(PAGE_BYTES - 4));
        found     = 1'b0;
        k         = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (small_req)
                lim = (LIM_W'(8) << i) - LIM_W'(4);
            else
                lim = (LIM_W'(8) << i) + LIM_W'(PAGE_BYTES - 4);
            if (!found && (small_req || i >= PAGE_CLASS) && ({2'b00, req} <= lim))
            begin
                found = 1'b1;
                k     = CLS_W'(i);
            end
        end
        return {found, k};
    endfunction

endpackage

// ----- hdl/pba_req_if.sv -----
// Request channel of the bucket allocator: valid/ready plus one request item.
// Depends on nothing.
interface pba_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [23:0] request_bytes;
    logic [15:0] free_address;

    modport source (output valid, output operation, output request_bytes,
                    output free_address, input ready);
    modport sink   (input valid, input operation, input request_bytes,
                    input free_address, output ready);
endinterface

// ----- hdl/pba_rsp_if.sv -----
// Response channel of the bucket allocator: valid/ready plus one result item.
// Depends on nothing.
interface pba_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] block_address;
    logic [1:0]  status;
    logic [3:0]  size_class;
    logic        page_reclaimed;

    modport source (output valid, output block_address, output status,
                    output size_class, output page_reclaimed, input ready);
    modport sink   (input valid, input block_address, input status,
                    input size_class, input page_reclaimed, output ready);
endinterface

// ----- hdl/pba_hdr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pba_hdr_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 18
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/pba_ctrl.sv -----
// Sequencer of the bucket allocator: list heads, break, output register and
// the read-modify-write walks over the header memory.
// Depends on pba_pkg, pba_req_if and pba_rsp_if.
module pba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    pba_req_if.sink            req,
    pba_rsp_if.source          rsp,
    output pba_pkg::mem_req_t  mem,
    input  pba_pkg::hdr_t      rd_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CARVE_SEL,
        S_POOL_RD,
        S_FILL,
        S_POP_RD,
        S_POP_WB,
        S_FREE_CHK,
        S_RC_CHK_RD,
        S_RC_CHK,
        S_WALK,
        S_WALK_DATA,
        S_RC_END
    } state_t;

    state_t                            state_reg;
    pba_pkg::head_t                    head_reg [pba_pkg::NUM_HEADS];
    logic [pba_pkg::ADDR_W:0]          brk_reg;
    logic [pba_pkg::CLS_W-1:0]         k_reg;
    logic [pba_pkg::ADDR_W-1:0]        h_reg;
    logic [pba_pkg::ADDR_W-1:0]        start_reg;
    logic [pba_pkg::GRAN_W-1:0]        g_reg;
    logic [pba_pkg::GRAN_W-1:0]        last_g_reg;
    logic [pba_pkg::PG_W-1:0]          i_reg;
    pba_pkg::head_t                    cur_reg;
    pba_pkg::head_t                    prev_reg;
    logic [pba_pkg::GRAN_W:0]          steps_reg;
    logic [pba_pkg::GRAN_W:0]          count_reg;
    logic                              rd_ok_reg;
    logic                              out_valid_reg;
    logic [pba_pkg::ADDR_W-1:0]        addr_reg;
    pba_pkg::status_t                  status_reg;
    logic [pba_pkg::CLS_W-1:0]         cls_reg;
    logic                              rec_reg;

    logic                              accept;
    logic [pba_pkg::CLS_W:0]           cls_req;
    logic [pba_pkg::ADDR_W-1:0]        fa_h;
    logic                              fa_bad;
    pba_pkg::hdr_t                     hdr_m;
    pba_pkg::head_t                    head_k;
    logic                              small_k;
    logic                              pool_take;
    logic [pba_pkg::ADDR_W+1:0]        amt;
    logic                              fits;
    logic [pba_pkg::GRAN_W-1:0]        blk_g;
    logic                              fill_link;
    logic [pba_pkg::GRAN_W-1:0]        link_gran;
    pba_pkg::hdr_t                     fill_val;
    logic                              free_ok;
    logic [pba_pkg::CLS_W-1:0]         free_k;
    logic                              reclaim_k;
    logic [pba_pkg::PG_W-1:0]          blk_ofs;
    logic [pba_pkg::PG_W-1:0]          i_last;
    logic                              walk_go;
    pba_pkg::head_t                    next_h;
    logic [pba_pkg::PAGE_SH-1:0]       sz_mask;
    logic                              in_page;
    logic                              count_ok;
    logic [pba_pkg::ADDR_W-1:0]        rd_ofs;

    assign accept  = req.valid && req.ready;
    assign cls_req = pba_pkg::class_of(req.request_bytes);
    assign fa_h    = req.free_address - pba_pkg::ADDR_W'(4);
    assign fa_bad  = (req.free_address < pba_pkg::ADDR_W'(4)) || (fa_h[2:0] != 3'b000)
                     || ({1'b0, fa_h} >= brk_reg);
    // Reads beyond the break or misaligned count as an all-zero header
    assign hdr_m   = rd_data & {pba_pkg::HDR_W{rd_ok_reg}};
    assign head_k  = head_reg[k_reg];
    assign small_k = (k_reg < pba_pkg::CLS_W'(pba_pkg::PAGE_CLASS));

    // Carve planning
    assign pool_take = small_k && !head_reg[pba_pkg::POOL][pba_pkg::HEAD_NULL_B];
    assign amt = small_k ? (pba_pkg::ADDR_W+2)'(pba_pkg::PAGE_BYTES)
                         : ((pba_pkg::ADDR_W+2)'(8) << k_reg)
                           + (pba_pkg::ADDR_W+2)'(pba_pkg::PAGE_BYTES);
    assign fits = ({1'b0, brk_reg} + amt) <= (pba_pkg::ADDR_W+2)'(pba_pkg::HEAP_BYTES);

    // Fill pattern: blocks linked in address order, last block and body zero
    assign blk_g     = pba_pkg::GRAN_W'(1) << k_reg;
    assign fill_link = small_k && ((g_reg & (blk_g - pba_pkg::GRAN_W'(1))) == '0)
                       && ((g_reg + blk_g) < pba_pkg::GRAN_W'(pba_pkg::PAGE_GRAN));
    assign link_gran = start_reg[pba_pkg::ADDR_W-1:3] + g_reg + blk_g;
    assign fill_val  = fill_link ? {1'b0, 1'b1, link_gran, 3'b000} : '0;

    // Free checks
    assign free_ok   = hdr_m[pba_pkg::HDR_ALLOC_B]
                       && (hdr_m[pba_pkg::HDR_CLS_W-1:0]
                           < pba_pkg::HDR_CLS_W'(pba_pkg::NUM_CLASSES));
    assign free_k    = hdr_m[pba_pkg::CLS_W-1:0];
    assign reclaim_k = (k_reg >= pba_pkg::CLS_W'(pba_pkg::MIN_RECLAIM_CLASS)) && small_k;

    // Reclaim scan and list walk
    assign blk_ofs  = pba_pkg::PG_W'(i_reg << k_reg);
    assign i_last   = pba_pkg::PG_W'((pba_pkg::PAGE_GRAN >> k_reg) - 1);
    assign walk_go  = !cur_reg[pba_pkg::HEAD_NULL_B]
                      && (steps_reg <= (pba_pkg::GRAN_W+1)'(pba_pkg::GRANULES));
    assign next_h   = pba_pkg::head_of_link(hdr_m);
    assign sz_mask  = (pba_pkg::PAGE_SH'(8) << k_reg) - pba_pkg::PAGE_SH'(1);
    assign in_page  = (cur_reg[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SH]
                       == h_reg[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SH])
                      && ((cur_reg[pba_pkg::PAGE_SH-1:0] & sz_mask) == '0);
    assign count_ok = (count_reg == (pba_pkg::GRAN_W+1)'(pba_pkg::PAGE_GRAN >> k_reg));

    // Header memory port requests
    always_comb
    begin
        mem    = '0;
        rd_ofs = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.operation == pba_pkg::OP_FREE)
                begin
                    rd_ofs     = fa_h;
                    mem.rd_en  = 1'b1;
                end
            end
            S_CARVE_SEL:
            begin
                if (pool_take)
                begin
                    rd_ofs    = head_reg[pba_pkg::POOL][pba_pkg::ADDR_W-1:0];
                    mem.rd_en = 1'b1;
                end
            end
            S_FILL:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = start_reg[pba_pkg::ADDR_W-1:3] + g_reg;
                mem.wr_data = fill_val;
            end
            S_POP_RD:
            begin
                rd_ofs    = head_k[pba_pkg::ADDR_W-1:0];
                mem.rd_en = 1'b1;
            end
            S_POP_WB:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = head_k[pba_pkg::ADDR_W-1:3];
                mem.wr_data = {1'b1, 1'b0, (pba_pkg::ADDR_W-pba_pkg::CLS_W)'(0), k_reg};
            end
            S_FREE_CHK:
            begin
                if (free_ok)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = h_reg[pba_pkg::ADDR_W-1:3];
                    mem.wr_data = pba_pkg::link_of_head(head_reg[free_k]);
                end
            end
            S_RC_CHK_RD:
            begin
                rd_ofs    = {h_reg[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SH], blk_ofs, 3'b000};
                mem.rd_en = 1'b1;
            end
            S_WALK:
            begin
                if (walk_go)
                begin
                    rd_ofs    = cur_reg[pba_pkg::ADDR_W-1:0];
                    mem.rd_en = 1'b1;
                end
            end
            S_WALK_DATA:
            begin
                if (in_page && !prev_reg[pba_pkg::HEAD_NULL_B])
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = prev_reg[pba_pkg::ADDR_W-1:3];
                    mem.wr_data = pba_pkg::link_of_head(next_h);
                end
            end
            S_RC_END:
            begin
                if (count_ok)
                begin
                    mem.wr_en   = 1'b1;
                    mem.wr_addr = {h_reg[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SH],
                                   pba_pkg::PG_W'(0)};
                    mem.wr_data = pba_pkg::link_of_head(head_reg[pba_pkg::POOL]);
                end
            end
            S_POOL_RD, S_RC_CHK:
            begin
                mem = '0;
            end
            default:
            begin
                mem = '0;
            end
        endcase
        mem.rd_addr = rd_ofs[pba_pkg::ADDR_W-1:3];
    end

    assign req.ready          = (state_reg == S_IDLE) && !out_valid_reg;
    assign rsp.valid          = out_valid_reg;
    assign rsp.block_address  = addr_reg;
    assign rsp.status         = status_reg;
    assign rsp.size_class     = cls_reg;
    assign rsp.page_reclaimed = rec_reg;

    // Sequencer, list heads, break and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int j = 0; j < pba_pkg::NUM_HEADS; j++)
            begin
                head_reg[j] <= pba_pkg::HEAD_EMPTY;
            end
            brk_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            k_reg         <= '0;
            h_reg         <= '0;
            start_reg     <= '0;
            g_reg         <= '0;
            last_g_reg    <= '0;
            i_reg         <= '0;
            cur_reg       <= pba_pkg::HEAD_EMPTY;
            prev_reg      <= pba_pkg::HEAD_EMPTY;
            steps_reg     <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            status_reg    <= pba_pkg::ST_DONE;
            cls_reg       <= '0;
            rec_reg       <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= (rd_ofs[2:0] == 3'b000) && ({1'b0, rd_ofs} < brk_reg);
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        addr_reg <= '0;
                        rec_reg  <= 1'b0;
                        if (req.operation == pba_pkg::OP_ALLOC)
                        begin
                            k_reg <= cls_req[pba_pkg::CLS_W-1:0];
                            if (!cls_req[pba_pkg::CLS_W])
                            begin
                                status_reg    <= pba_pkg::ST_OOM;
                                cls_reg       <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            else if (head_reg[cls_req[pba_pkg::CLS_W-1:0]][pba_pkg::HEAD_NULL_B])
                            begin
                                state_reg <= S_CARVE_SEL;
                            end
                            else
                            begin
                                state_reg <= S_POP_RD;
                            end
                        end
                        else
                        begin
                            h_reg <= fa_h;
                            if (fa_bad)
                            begin
                                status_reg    <= pba_pkg::ST_IGNORED;
                                cls_reg       <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_FREE_CHK;
                            end
                        end
                    end
                end

                // Take a pooled page, or new memory at the break, else report out of memory
                S_CARVE_SEL:
                begin
                    g_reg <= '0;
                    if (pool_take)
                    begin
                        start_reg  <= head_reg[pba_pkg::POOL][pba_pkg::ADDR_W-1:0];
                        last_g_reg <= pba_pkg::GRAN_W'(pba_pkg::PAGE_GRAN - 1);
                        state_reg  <= S_POOL_RD;
                    end
                    else if (!fits)
                    begin
                        status_reg    <= pba_pkg::ST_OOM;
                        cls_reg       <= k_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        start_reg  <= brk_reg[pba_pkg::ADDR_W-1:0];
                        brk_reg    <= brk_reg + pba_pkg::ADDR_W'(amt);
                        last_g_reg <= pba_pkg::GRAN_W'((amt >> 3) - 1);
                        state_reg  <= S_FILL;
                    end
                end

                S_POOL_RD:
                begin
                    head_reg[pba_pkg::POOL] <= next_h;
                    state_reg               <= S_FILL;
                end

                // One granule header per cycle
                S_FILL:
                begin
                    g_reg <= g_reg + pba_pkg::GRAN_W'(1);
                    if (g_reg == last_g_reg)
                    begin
                        head_reg[k_reg] <= {1'b0, start_reg};
                        state_reg       <= S_POP_RD;
                    end
                end

                S_POP_RD:
                begin
                    state_reg <= S_POP_WB;
                end

                S_POP_WB:
                begin
                    head_reg[k_reg] <= next_h;
                    addr_reg        <= head_k[pba_pkg::ADDR_W-1:0] + pba_pkg::ADDR_W'(4);
                    status_reg      <= pba_pkg::ST_DONE;
                    cls_reg         <= k_reg;
                    out_valid_reg   <= 1'b1;
                    state_reg       <= S_IDLE;
                end

                // Push the freed block, then decide on a page reclaim; ignore a bad header
                S_FREE_CHK:
                begin
                    if (!free_ok)
                    begin
                        status_reg    <= pba_pkg::ST_IGNORED;
                        cls_reg       <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        k_reg            <= free_k;
                        head_reg[free_k] <= {1'b0, h_reg};
                        cls_reg          <= free_k;
                        status_reg       <= pba_pkg::ST_DONE;
                        i_reg            <= '0;
                        state_reg        <= S_RC_CHK_RD;
                    end
                end

                S_RC_CHK_RD:
                begin
                    if (!reclaim_k)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RC_CHK;
                    end
                end

                // Any block of the page still allocated ends the reclaim
                S_RC_CHK:
                begin
                    if (hdr_m[pba_pkg::HDR_ALLOC_B])
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else if (i_reg == i_last)
                    begin
                        cur_reg   <= head_k;
                        prev_reg  <= pba_pkg::HEAD_EMPTY;
                        steps_reg <= '0;
                        count_reg <= '0;
                        state_reg <= S_WALK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + pba_pkg::PG_W'(1);
                        state_reg <= S_RC_CHK_RD;
                    end
                end

                S_WALK:
                begin
                    if (walk_go)
                    begin
                        steps_reg <= steps_reg + (pba_pkg::GRAN_W+1)'(1);
                        state_reg <= S_WALK_DATA;
                    end
                    else
                    begin
                        state_reg <= S_RC_END;
                    end
                end

                // Unlink entries that lie in the page
                S_WALK_DATA:
                begin
                    if (in_page)
                    begin
                        if (prev_reg[pba_pkg::HEAD_NULL_B])
                        begin
                            head_reg[k_reg] <= next_h;
                        end
                        count_reg <= count_reg + (pba_pkg::GRAN_W+1)'(1);
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                    end
                    cur_reg   <= next_h;
                    state_reg <= S_WALK;
                end

                S_RC_END:
                begin
                    if (count_ok)
                    begin
                        head_reg[pba_pkg::POOL] <= {1'b0,
                            h_reg[pba_pkg::ADDR_W-1:pba_pkg::PAGE_SH], pba_pkg::PAGE_SH'(0)};
                        rec_reg <= 1'b1;
                    end
                    else
                    begin
                        status_reg <= pba_pkg::ST_CORRUPT;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/power_of_two_bucket_allocator_unit.sv -----
// Top level of the power-of-two bucket allocator.
// Depends on pba_pkg, pba_req_if, pba_rsp_if, pba_hdr_ram and pba_ctrl.
//
// Usage:
//   req carries one item per valid/ready handshake: operation (0 allocate,
//   1 free), request_bytes for allocate, free_address for free.
//   rsp returns exactly one item per request: block_address, status,
//   size_class and page_reclaimed, held in an output register until taken.
// Sequence: a rejected class or address is answered straight from idle.
//   A free reads the header, pushes the block and, for a small class of 2
//   or more, checks the block headers of its page and, if all are free, walks the class list.
//   An allocate pops the class list; if it is empty, it first takes a pooled
//   page (reading the pool link) or memory at the break, writing a header per
//   8-byte granule: a page for a small class, 2^(k+3)+4096 bytes for a large one.
// req.ready is high only when the sequencer is idle and the previous result
// has been taken, so a stalled receiver holds off new requests.
// Reset empties all lists and the page pool and puts the break at zero; no
// memory clearing pass is needed, headers past the break read as zero.
module power_of_two_bucket_allocator_unit (
    input  logic      clk,
    input  logic      rst_n,
    pba_req_if.sink   req,
    pba_rsp_if.source rsp
);

    pba_pkg::mem_req_t mem;
    pba_pkg::hdr_t     rd_data;

    pba_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem     (mem),
        .rd_data (rd_data)
    );

    pba_hdr_ram #(
        .DEPTH (pba_pkg::GRANULES),
        .WIDTH (pba_pkg::HDR_W)
    ) u_hdr_ram (
        .clk     (clk),
        .rd_en   (mem.rd_en),
        .rd_addr (mem.rd_addr),
        .rd_data (rd_data),
        .wr_en   (mem.wr_en),
        .wr_addr (mem.wr_addr),
        .wr_data (mem.wr_data)
    );

endmodule

// ----- verif/tb.sv -----
// Testbench for power_of_two_bucket_allocator_unit: directed table plus random
// allocate/free traffic, each response item checked against the table's expected item or an allocator predictor.
// Depends on pba_pkg, pba_req_if, pba_rsp_if and the RTL top level.
`timescale 1ns / 1ps

module tb;

    typedef enum int {
        RC_NONE,
        RC_POOLED,
        RC_MISMATCH
    } reclaim_t;

    typedef struct packed {
        logic [15:0]      addr;
        pba_pkg::status_t st;
        logic [3:0]       cls;
        logic             rec;
    } alloc_result_t;

    typedef struct {
        logic          op;
        logic [23:0]   bytes;
        logic [15:0]   faddr;
        bit            typed;
        alloc_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pba_req_if req ();
    pba_rsp_if rsp ();

    power_of_two_bucket_allocator_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Allocator shadow state
    pba_pkg::head_t list_head [pba_pkg::NUM_HEADS];
    pba_pkg::hdr_t  gran_hdr  [pba_pkg::GRANULES];
    logic [16:0]    brk;

    alloc_result_t expected_q[$];
    logic [15:0]   live_blocks[$];
    int            errors;
    int            taken;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic pba_pkg::hdr_t hdr_rd(input int ofs);
        if (ofs < 0 || ofs >= int'(brk) || (ofs % 8) != 0 || (ofs / 8) >= pba_pkg::GRANULES)
            return '0;
        return gran_hdr[ofs / 8];
    endfunction

    function automatic void hdr_wr(input int ofs, input pba_pkg::hdr_t v);
        if ((ofs % 8) == 0 && ofs >= 0 && (ofs / 8) < pba_pkg::GRANULES)
            gran_hdr[ofs / 8] = v;
    endfunction

    // Successor of a header as a list head; allocated or unlinked is empty
    function automatic pba_pkg::head_t succ_head(input pba_pkg::hdr_t h);
        if (h[pba_pkg::HDR_ALLOC_B] || !h[pba_pkg::HDR_LINK_B])
            return pba_pkg::HEAD_EMPTY;
        return {1'b0, h[pba_pkg::ADDR_W-1:0]};
    endfunction

    function automatic pba_pkg::hdr_t link_to(input pba_pkg::head_t hd);
        if (hd[pba_pkg::HEAD_NULL_B])
            return '0;
        return {2'b01, hd[pba_pkg::ADDR_W-1:0]};
    endfunction

    // Size class choice; returns -1 when no class fits
    function automatic int pick_class(input longint unsigned rq);
        int k;
        if (rq + 4 <= pba_pkg::PAGE_BYTES)
        begin
            k = 0;
            while (rq > (longint'(8) << k) - 4)
            begin
                k++;
                if (k >= pba_pkg::NUM_CLASSES)
                    return -1;
            end
        end
        else
        begin
            k = pba_pkg::PAGE_CLASS;
            while (rq > (longint'(8) << k) + pba_pkg::PAGE_BYTES - 4)
            begin
                k++;
                if (k >= pba_pkg::NUM_CLASSES)
                    return -1;
            end
        end
        return k;
    endfunction

    // Refill class k from the page pool or the break
    function automatic bit carve_class(input int k);
        longint sz, amt, nblk;
        int     start;
        bit     got;
        sz   = longint'(8) << k;
        got  = 1'b0;
        start = 0;
        if (sz < pba_pkg::PAGE_BYTES)
        begin
            amt  = pba_pkg::PAGE_BYTES;
            nblk = pba_pkg::PAGE_BYTES / sz;
            if (!list_head[pba_pkg::POOL][pba_pkg::HEAD_NULL_B])
            begin
                start = int'(list_head[pba_pkg::POOL][pba_pkg::ADDR_W-1:0]);
                list_head[pba_pkg::POOL] = succ_head(hdr_rd(start));
                got = 1'b1;
            end
        end
        else
        begin
            amt  = sz + pba_pkg::PAGE_BYTES;
            nblk = 1;
        end
        if (!got)
        begin
            if (longint'(brk) + amt > pba_pkg::HEAP_BYTES)
                return 1'b0;
            start = int'(brk);
            brk   = 17'(longint'(brk) + amt);
        end
        for (longint o = 0; o < amt; o += 8)
            hdr_wr(start + int'(o), '0);
        for (longint i = 0; i < nblk; i++)
            hdr_wr(start + int'(i * sz), (i + 1 < nblk) ?
                   {2'b01, 16'(start + int'((i + 1) * sz))} : pba_pkg::hdr_t'(0));
        list_head[k] = {1'b0, 16'(start)};
        return 1'b1;
    endfunction

    // Page reclaim after a free
    function automatic reclaim_t reclaim_page(input int h, input int k);
        int             sz, nblk, p0, pend, cnt, steps;
        pba_pkg::head_t cur, prv, nxt;
        pba_pkg::hdr_t  hv;
        int             c;
        sz = 8 << k;
        if (sz >= pba_pkg::PAGE_BYTES || sz < 32)
            return RC_NONE;
        p0   = h - (h % pba_pkg::PAGE_BYTES);
        pend = p0 + pba_pkg::PAGE_BYTES;
        nblk = pba_pkg::PAGE_BYTES / sz;
        for (int i = 0; i < nblk; i++)
        begin
            hv = hdr_rd(p0 + i * sz);
            if (hv[pba_pkg::HDR_ALLOC_B])
                return RC_NONE;
        end
        cur = list_head[k];
        prv = pba_pkg::HEAD_EMPTY;
        cnt = 0;
        steps = 0;
        while (!cur[pba_pkg::HEAD_NULL_B] && steps <= pba_pkg::GRANULES)
        begin
            steps++;
            c   = int'(cur[pba_pkg::ADDR_W-1:0]);
            nxt = succ_head(hdr_rd(c));
            if (c >= p0 && c < pend && ((c - p0) % sz) == 0 && (c - p0) / sz < nblk)
            begin
                if (prv[pba_pkg::HEAD_NULL_B])
                    list_head[k] = nxt;
                else
                    hdr_wr(int'(prv[pba_pkg::ADDR_W-1:0]), link_to(nxt));
                cnt++;
            end
            else
                prv = cur;
            cur = nxt;
        end
        if (cnt != nblk)
            return RC_MISMATCH;
        hdr_wr(p0, link_to(list_head[pba_pkg::POOL]));
        list_head[pba_pkg::POOL] = {1'b0, 16'(p0)};
        return RC_POOLED;
    endfunction

    function automatic alloc_result_t predict_alloc_op(input logic op,
                                                       input logic [23:0] bytes,
                                                       input logic [15:0] faddr);
        alloc_result_t r;
        int            k, h;
        reclaim_t      rc;
        pba_pkg::hdr_t hv;
        r = '{addr: '0, st: pba_pkg::ST_DONE, cls: '0, rec: 1'b0};
        if (op == pba_pkg::OP_ALLOC)
        begin
            k = pick_class(bytes);
            if (k < 0)
                r.st = pba_pkg::ST_OOM;
            else
            begin
                r.cls = 4'(k);
                if (list_head[k][pba_pkg::HEAD_NULL_B] && !carve_class(k))
                    r.st = pba_pkg::ST_OOM;
                else
                begin
                    h = int'(list_head[k][pba_pkg::ADDR_W-1:0]);
                    list_head[k] = succ_head(hdr_rd(h));
                    hdr_wr(h, {2'b10, 16'(k)});
                    r.addr = 16'(h + 4);
                end
            end
        end
        else
        begin
            hv = (faddr >= 4) ? hdr_rd(int'(faddr) - 4) : pba_pkg::hdr_t'(0);
            if (!hv[pba_pkg::HDR_ALLOC_B]
                || hv[pba_pkg::HDR_CLS_W-1:0] >= pba_pkg::NUM_CLASSES)
                r.st = pba_pkg::ST_IGNORED;
            else
            begin
                h = int'(faddr) - 4;
                k = int'(hv[pba_pkg::HDR_CLS_W-1:0]);
                r.cls = 4'(k);
                hdr_wr(h, link_to(list_head[k]));
                list_head[k] = {1'b0, 16'(h)};
                rc = reclaim_page(h, k);
                if (rc == RC_MISMATCH)
                    r.st = pba_pkg::ST_CORRUPT;
                else if (rc == RC_POOLED)
                    r.rec = 1'b1;
            end
        end
        return r;
    endfunction

    // Offer one item and hold it until accepted; then maybe pause
    task automatic send_item(input logic op, input logic [23:0] bytes,
                             input logic [15:0] faddr, input int gap);
        req.valid         <= 1'b1;
        req.operation     <= op;
        req.request_bytes <= bytes;
        req.free_address  <= faddr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Predict, record and send one item
    task automatic issue(input logic op, input logic [23:0] bytes,
                         input logic [15:0] faddr, input bit typed,
                         input alloc_result_t want, input int gap);
        alloc_result_t p;
        p = predict_alloc_op(op, bytes, faddr);
        expected_q.push_back(typed ? want : p);
        if (op == pba_pkg::OP_ALLOC && p.st == pba_pkg::ST_DONE)
            live_blocks.push_back(p.addr);
        send_item(op, bytes, faddr, gap);
    endtask

    // Response checker and receiver stall pattern
    initial
    begin
        alloc_result_t e;
        int hold;
        bit long_done;
        rsp.ready = 1'b0;
        taken = 0;
        errors = 0;
        hold = 0;
        long_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                taken++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected item addr=%0d status=%0d", $realtime,
                             rsp.block_address, rsp.status);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (rsp.block_address !== e.addr || rsp.status !== e.st ||
                        rsp.size_class !== e.cls || rsp.page_reclaimed !== e.rec)
                    begin
                        $display("%0t: mismatch expected addr=%0d st=%0d cls=%0d rec=%0d",
                                 $realtime, e.addr, e.st, e.cls, e.rec);
                        $display("%0t:          actual addr=%0d st=%0d cls=%0d rec=%0d",
                                 $realtime, rsp.block_address, rsp.status,
                                 rsp.size_class, rsp.page_reclaimed);
                        errors++;
                    end
                end
            end
            // one long hold-off while the sender keeps offering
            if (!long_done && taken == 300)
            begin
                long_done = 1'b1;
                hold = 3000;
            end
            if (hold > 0)
            begin
                hold--;
                rsp.ready <= 1'b0;
            end
            else if ((taken / 100) % 3 == 0)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t dir_rows[$];
        stim_row_t row;
        int burst, gap, r, idx;
        logic [23:0] bytes;
        alloc_result_t none;

        none = '{addr: '0, st: pba_pkg::ST_DONE, cls: '0, rec: 1'b0};
        req.valid = 1'b0;
        req.operation = pba_pkg::OP_ALLOC;
        req.request_bytes = '0;
        req.free_address = '0;
        for (int i = 0; i < pba_pkg::NUM_HEADS; i++)
            list_head[i] = pba_pkg::HEAD_EMPTY;
        for (int i = 0; i < pba_pkg::GRANULES; i++)
            gran_hdr[i] = '0;
        brk = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // op, bytes, free address, typed, expected
        dir_rows = '{
            '{pba_pkg::OP_ALLOC, 24'd0, 16'd0, 1, '{16'd4, pba_pkg::ST_DONE, 4'd0, 1'b0}},
            '{pba_pkg::OP_ALLOC, 24'd24, 16'd0, 1, '{16'd4100, pba_pkg::ST_DONE, 4'd2, 1'b0}},
            '{pba_pkg::OP_ALLOC, 24'hFFFFFF, 16'd0, 1, '{16'd0, pba_pkg::ST_OOM, 4'd0, 1'b0}},
            '{pba_pkg::OP_FREE, 24'd0, 16'd0, 1, '{16'd0, pba_pkg::ST_IGNORED, 4'd0, 1'b0}},
            '{pba_pkg::OP_FREE, 24'd0, 16'd2, 1, '{16'd0, pba_pkg::ST_IGNORED, 4'd0, 1'b0}},
            '{pba_pkg::OP_FREE, 24'd0, 16'hFFFF, 1, '{16'd0, pba_pkg::ST_IGNORED, 4'd0, 1'b0}},
            '{pba_pkg::OP_FREE, 24'd0, 16'd4100, 1, '{16'd0, pba_pkg::ST_DONE, 4'd2, 1'b1}},
            '{pba_pkg::OP_ALLOC, 24'd4092, 16'd0, 1, '{16'd8196, pba_pkg::ST_DONE, 4'd9, 1'b0}},
            '{pba_pkg::OP_ALLOC, 24'd4093, 16'd0, 1, '{16'd16388, pba_pkg::ST_DONE, 4'd9, 1'b0}},
            '{pba_pkg::OP_ALLOC, 24'd36860, 16'd0, 1,
              '{16'd24580, pba_pkg::ST_DONE, 4'd12, 1'b0}},
            '{pba_pkg::OP_ALLOC, 24'd36861, 16'd0, 1, '{16'd0, pba_pkg::ST_OOM, 4'd0, 1'b0}},
            '{pba_pkg::OP_FREE, 24'd0, 16'd24580, 1, '{16'd0, pba_pkg::ST_DONE, 4'd12, 1'b0}},
            '{pba_pkg::OP_FREE, 24'd0, 16'd24580, 1,
              '{16'd0, pba_pkg::ST_IGNORED, 4'd0, 1'b0}},
            '{pba_pkg::OP_ALLOC, 24'd24, 16'd0, 1, '{16'd4100, pba_pkg::ST_DONE, 4'd2, 1'b0}},
            '{pba_pkg::OP_ALLOC, 24'd12, 16'd0, 0, none},
            '{pba_pkg::OP_ALLOC, 24'd13, 16'd0, 0, none},
            '{pba_pkg::OP_ALLOC, 24'd60, 16'd0, 0, none},
            '{pba_pkg::OP_ALLOC, 24'd2044, 16'd0, 0, none},
            '{pba_pkg::OP_ALLOC, 24'd12284, 16'd0, 0, none},
            '{pba_pkg::OP_FREE, 24'd0, 16'd8, 0, none},
            '{pba_pkg::OP_FREE, 24'd0, 16'd12, 0, none},
            '{pba_pkg::OP_FREE, 24'd0, 16'd8196, 0, none}
        };
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            issue(row.op, row.bytes, row.faddr, row.typed, row.want,
                  (i % 4 == 3) ? $urandom_range(1, 5) : 0);
        end
        // directed blocks stay allocated; random frees start from a clean list
        live_blocks.delete();

        // Random part: bursts of traffic with gaps between them
        burst = 0;
        for (int n = 0; n < 1330; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                gap = $urandom_range(1, 30);
            end
            else
                gap = 0;
            burst--;
            r = $urandom_range(0, 99);
            if (live_blocks.size() > 150)
                r = r % 45;
            if (live_blocks.size() > 0 && r < 45)
            begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                issue(pba_pkg::OP_FREE, 24'($urandom), live_blocks[idx], 0, none,
                      burst == 0 ? gap : 0);
                live_blocks.delete(idx);
            end
            else if (r < 52)
            begin
                // stray or misaligned free
                issue(pba_pkg::OP_FREE, 24'($urandom), 16'($urandom), 0, none,
                      burst == 0 ? gap : 0);
            end
            else if (r < 55)
            begin
                issue(pba_pkg::OP_ALLOC, 24'($urandom), 16'($urandom), 0, none,
                      burst == 0 ? gap : 0);
            end
            else
            begin
                if (r < 58)
                    bytes = 24'($urandom_range(4093, 36861));
                else
                    bytes = 24'($urandom_range(0, 1 << $urandom_range(2, 12)));
                issue(pba_pkg::OP_ALLOC, bytes, 16'($urandom), 0, none,
                      burst == 0 ? gap : 0);
            end
        end
        req.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
